// ===== hw/rtl/pfla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_pkg
// shared types and constants for the page free-list allocator
// ----------------------------------------------------------------------------
package pfla_pkg;

  // page space
  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_W     = 10;
  localparam int TOTAL_W    = 11;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // request transaction
  typedef struct packed {
    logic              kind;
    logic [PAGE_W-1:0] page_number;
  } in_t;

  // result transaction
  typedef struct packed {
    status_t            status;
    logic [PAGE_W-1:0]  given_page;
    logic [PAGE_W-1:0]  free_total;
    logic [TOTAL_W-1:0] pages_in_use_total;
  } out_t;

endpackage

// ===== hw/rtl/pfla_link_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_link_ram
// simple dual-port link store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfla_link_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 10,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/page_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_list_allocator
// hands out page numbers from a lifo free list or by bumping the page total
// ----------------------------------------------------------------------------
//
// channel   ports                      handshake
// -------   ------------------------   ------------------------------------
// request   start, busy, in_item       taken when start high and busy low
// result    out_valid, out_result      one-cycle strobe, always taken
//
// a result is shown in the cycle after its request is taken
// free, bump allocate and rejected requests leave busy low; an allocate popped
// from the free list raises busy while the link ram read is fetched
// reset clears head and free count and sets the page total to 1; the link store is not cleared
// the result side cannot stall, so no result is ever held back
// ----------------------------------------------------------------------------
module page_free_list_allocator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pfla_pkg::in_t   in_item,
  output logic            out_valid,
  output pfla_pkg::out_t  out_result
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t                        state_r, state_nxt;
  logic [pfla_pkg::PAGE_W-1:0]   head_r, head_nxt;
  logic [pfla_pkg::PAGE_W-1:0]   count_r, count_nxt;
  logic [pfla_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic                          out_valid_r, out_valid_nxt;
  pfla_pkg::out_t                out_r, out_nxt;

  logic                          accept;
  logic                          wr_en;
  logic                          rd_en;
  logic [pfla_pkg::PAGE_W-1:0]   link_rd;

  assign accept = start && !busy;

  // link store
  pfla_link_ram #(
    .DEPTH (pfla_pkg::MAX_PAGES),
    .WIDTH (pfla_pkg::PAGE_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_item.page_number),
    .wr_data (head_r),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (link_rd)
  );

  // next-state and result logic
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    case (state_r)
      S_POP: begin
        // link read is back, move the head down the list
        head_nxt  = link_rd;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt      = 1'b1;
          out_nxt.status     = pfla_pkg::ST_OK;
          out_nxt.given_page = '0;
          if (in_item.kind == pfla_pkg::KIND_FREE) begin
            if (in_item.page_number == '0) begin
              // header page cannot be freed
              out_nxt.status = pfla_pkg::ST_NOFREE;
            end else begin
              // push onto the list
              wr_en    = 1'b1;
              head_nxt = in_item.page_number;
              if (count_r != pfla_pkg::PAGE_W'(pfla_pkg::MAX_PAGES - 1)) begin
                count_nxt = count_r + 1'b1;
              end
            end
          end else begin
            if (head_r != '0) begin
              // pop the head, fetch its link
              rd_en              = 1'b1;
              out_nxt.given_page = head_r;
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
              state_nxt = S_POP;
            end else if (total_r < pfla_pkg::TOTAL_W'(pfla_pkg::MAX_PAGES)) begin
              // take the next never-used page
              out_nxt.given_page = total_r[pfla_pkg::PAGE_W-1:0];
              total_nxt          = total_r + 1'b1;
            end else begin
              out_nxt.status = pfla_pkg::ST_FULL;
            end
          end
          out_nxt.free_total         = count_nxt;
          out_nxt.pages_in_use_total = total_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      total_r     <= pfla_pkg::TOTAL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign busy       = (state_r == S_POP);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

// ===== verif/page_free_list_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_list_allocator_test
// self-checking testbench for the page free-list allocator
//
// a queue of requests is filled up front: a short directed opening, then
// random phases of mixed, allocate-heavy and free-heavy traffic. a
// clocked driver issues requests with random gaps and no-gap bursts, a shadow
// of the allocator state predicts each result at acceptance, and a clocked
// monitor checks every result strobe field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module page_free_list_allocator_test;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  pfla_pkg::in_t  in_item;
  logic           out_valid;
  pfla_pkg::out_t out_result;

  // pending requests and predicted results
  pfla_pkg::in_t  req_q[$];
  pfla_pkg::out_t result_q[$];

  // shadow allocator state
  logic [pfla_pkg::PAGE_W-1:0]  shadow_head;
  logic [pfla_pkg::PAGE_W-1:0]  shadow_free;
  logic [pfla_pkg::TOTAL_W-1:0] shadow_total;
  logic [pfla_pkg::PAGE_W-1:0]  shadow_link [0:pfla_pkg::MAX_PAGES-1];

  // coverage tallies
  int n_pop, n_bump, n_full, n_push, n_reject, n_sat, n_zero_pop;
  int mismatches;

  // driver pacing
  int wait_left;
  bit no_idle;

  // request generation
  int gen_allocs;

  page_free_list_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // shadow of one allocator transaction, returns the expected result
  function automatic pfla_pkg::out_t predict_result(pfla_pkg::in_t req);
    pfla_pkg::out_t res;
    res.status     = pfla_pkg::ST_OK;
    res.given_page = '0;
    if (req.kind == pfla_pkg::KIND_ALLOC) begin
      if (shadow_head != '0) begin
        // pop the top of the free list
        res.given_page = shadow_head;
        shadow_head    = shadow_link[shadow_head];
        if (shadow_free > 0) shadow_free--;
        else n_zero_pop++;
        n_pop++;
      end else if (shadow_total < pfla_pkg::MAX_PAGES) begin
        // hand out a never-used page
        res.given_page = shadow_total[pfla_pkg::PAGE_W-1:0];
        shadow_total++;
        n_bump++;
      end else begin
        res.status = pfla_pkg::ST_FULL;
        n_full++;
      end
    end else begin
      if (req.page_number == '0) begin
        // header page stays put
        res.status = pfla_pkg::ST_NOFREE;
        n_reject++;
      end else begin
        shadow_link[req.page_number] = shadow_head;
        shadow_head                  = req.page_number;
        if (shadow_free < pfla_pkg::MAX_PAGES - 1) shadow_free++;
        else n_sat++;
        n_push++;
      end
    end
    res.free_total         = shadow_free;
    res.pages_in_use_total = shadow_total;
    return res;
  endfunction

  // one field of a result
  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // queue one request
  task automatic add_req(logic kind, int unsigned page);
    pfla_pkg::in_t req;
    req.kind        = kind;
    req.page_number = page[pfla_pkg::PAGE_W-1:0];
    req_q.push_back(req);
    if (kind == pfla_pkg::KIND_ALLOC) gen_allocs++;
  endtask

  // random phase: allocates at alloc_pct percent, else mostly frees of pages that
  // may have been handed out, with some header-page frees and frees of arbitrary pages as noise
  task automatic gen_phase(int count, int alloc_pct);
    int hi;
    int pick;
    for (int i = 0; i < count; i++) begin
      hi = (gen_allocs < 1) ? 1 : gen_allocs;
      if (hi > pfla_pkg::MAX_PAGES - 1) hi = pfla_pkg::MAX_PAGES - 1;
      if ($urandom_range(0, 99) < alloc_pct) begin
        add_req(pfla_pkg::KIND_ALLOC, $urandom_range(0, pfla_pkg::MAX_PAGES - 1));
      end else begin
        pick = $urandom_range(0, 31);
        if (pick == 0) add_req(pfla_pkg::KIND_FREE, 0);
        else if (pick < 3) add_req(pfla_pkg::KIND_FREE, $urandom_range(0, pfla_pkg::MAX_PAGES - 1));
        else add_req(pfla_pkg::KIND_FREE, $urandom_range(1, hi));
      end
    end
  endtask

  // driver: issue queued requests, predict on acceptance
  always @(posedge clk) begin : driver
    logic start_nx;
    start_nx = start;
    if (!rst_n) begin
      start_nx = 1'b0;
    end else begin
      if (start && !busy) begin
        result_q.push_back(predict_result(in_item));
        start_nx = 1'b0;
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        wait_left = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (!start_nx) begin
        if (wait_left > 0) begin
          wait_left--;
        end else if (req_q.size() > 0) begin
          in_item  <= req_q.pop_front();
          start_nx = 1'b1;
        end
      end
    end
    start <= start_nx;
  end

  // monitor: check each result strobe against the oldest prediction
  always @(posedge clk) begin : monitor
    pfla_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d page %0d",
                 $time, out_result.status, out_result.given_page);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        compare_field("status", want.status, out_result.status);
        compare_field("given_page", want.given_page, out_result.given_page);
        compare_field("free_total", want.free_total, out_result.free_total);
        compare_field("pages_in_use_total", want.pages_in_use_total,
                      out_result.pages_in_use_total);
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("page_free_list_allocator: mismatch");
    $finish;
  end

  // stimulus and end of run
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    wait_left    = 0;
    no_idle      = 1'b0;
    gen_allocs   = 0;
    mismatches   = 0;
    shadow_head  = '0;
    shadow_free  = '0;
    shadow_total = pfla_pkg::TOTAL_W'(1);
    for (int i = 0; i < pfla_pkg::MAX_PAGES; i++) shadow_link[i] = '0;

    // directed opening
    add_req(pfla_pkg::KIND_FREE, 0);           // header page free is rejected
    add_req(pfla_pkg::KIND_ALLOC, 0);          // bump to page 1
    add_req(pfla_pkg::KIND_ALLOC, 10'h3FF);    // page field ignored on allocate
    add_req(pfla_pkg::KIND_ALLOC, 10'h2AA);
    add_req(pfla_pkg::KIND_FREE, 2);
    add_req(pfla_pkg::KIND_FREE, 3);
    add_req(pfla_pkg::KIND_ALLOC, 10'h155);    // pop page 3
    add_req(pfla_pkg::KIND_ALLOC, 0);          // pop page 2 right behind
    add_req(pfla_pkg::KIND_ALLOC, 0);          // list empty again, bump
    add_req(pfla_pkg::KIND_FREE, 10'h3FF);     // page never handed out
    add_req(pfla_pkg::KIND_FREE, 10'h3FF);     // same page already free
    add_req(pfla_pkg::KIND_FREE, 10'h155);
    add_req(pfla_pkg::KIND_FREE, 10'h2AA);
    add_req(pfla_pkg::KIND_ALLOC, 0);
    add_req(pfla_pkg::KIND_ALLOC, 0);
    add_req(pfla_pkg::KIND_ALLOC, 0);
    add_req(pfla_pkg::KIND_ALLOC, 0);
    add_req(pfla_pkg::KIND_ALLOC, 0);          // page 3FF again, its link points to itself
    add_req(pfla_pkg::KIND_FREE, 1);
    add_req(pfla_pkg::KIND_FREE, 0);
    add_req(pfla_pkg::KIND_ALLOC, 0);

    // random: mixed traffic, then allocate-heavy, free-heavy and
    // allocate-heavy stretches
    gen_phase(200, 55);
    gen_phase(600, 97);
    gen_phase(430, 3);
    gen_phase(400, 97);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() > 0 || start || result_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d pops, %0d bump allocates, %0d full answers, %0d frees, %0d rejected",
             n_pop, n_bump, n_full, n_push, n_reject);
    $display("frees at saturated free count: %0d, pops at zero free count: %0d",
             n_sat, n_zero_pop);
    if (mismatches == 0) begin
      $display("page_free_list_allocator: match");
    end else begin
      $display("page_free_list_allocator: mismatch");
    end
    $finish;
  end

endmodule
